>>> src/bfs_pkg.sv
// ---------------------------------------------------------------------------
// bfs_pkg
// Shared types and defaults of the buffered frame selector.
// ---------------------------------------------------------------------------
`default_nettype none

package bfs_pkg;

	localparam int unsigned FRAME_BITS_DEF = 32;
	localparam int unsigned SLOT_BITS_DEF  = 8;

	// Why a selection was made.
	typedef enum logic [2:0] {
		REASON_NONE      = 3'd0,
		REASON_PREFERRED = 3'd1,
		REASON_EXACT     = 3'd2,
		REASON_BEFORE    = 3'd3,
		REASON_NEAREST   = 3'd4,
		REASON_RETAINED  = 3'd5
	} reason_t;

	// Fallback policy held in the configuration register.
	typedef enum logic [1:0] {
		FB_EXACT_ONLY     = 2'd0,
		FB_AT_OR_BEFORE   = 2'd1,
		FB_BEFORE_NEAREST = 2'd2,
		FB_NEAREST        = 2'd3
	} fallback_t;

	// Which of the four trackers currently hold a candidate.
	typedef struct packed {
		logic preferred;
		logic exact;
		logic at_or_before;
		logic nearest;
	} pick_found_t;

endpackage

`default_nettype wire

>>> src/buffered_frame_selector.sv
// ---------------------------------------------------------------------------
// buffered_frame_selector
// Picks one buffered frame from a run of candidates, one candidate a transfer.
// ---------------------------------------------------------------------------
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ---------------------------------------
//   in       in_valid / in_stall     candidate, last flag, request, retained
//   out      out_valid / out_stall   chosen_slot, chosen_frame, reason
//   cfg      cfg_wr_en               cfg_wr_data (fallback mode)
//
// An accepted transfer is held in the stage-one register, where the four
// trackers are updated; a new transfer can be taken every cycle while
// stage one does not stall. The last transfer of a run passes from stage
// one into the result register. Stage one stalls only when it holds a last
// transfer and the result register is still full and stalled. Reset closes
// any open run and sets the fallback mode to exact only.
//
`default_nettype none

module buffered_frame_selector #(
	parameter int unsigned FRAME_BITS = bfs_pkg::FRAME_BITS_DEF,
	parameter int unsigned SLOT_BITS  = bfs_pkg::SLOT_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,

	input  wire logic                         cfg_wr_en,
	input  wire logic [1:0]                   cfg_wr_data,

	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire logic                         candidate_valid,
	input  wire logic signed [SLOT_BITS:0]    candidate_slot,
	input  wire logic signed [FRAME_BITS-1:0] candidate_frame,
	input  wire logic                         last_candidate,
	input  wire logic signed [FRAME_BITS-1:0] wanted_frame,
	input  wire logic signed [FRAME_BITS-1:0] minimum_frame,
	input  wire logic signed [SLOT_BITS:0]    favoured_slot,
	input  wire logic signed [SLOT_BITS:0]    kept_slot,
	input  wire logic signed [FRAME_BITS-1:0] kept_frame,

	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic signed [SLOT_BITS:0]         chosen_slot,
	output logic signed [FRAME_BITS-1:0]      chosen_frame,
	output logic [2:0]                        selection_reason
);

	localparam int unsigned GAP_BITS = FRAME_BITS + 1;

	// Configuration.
	bfs_pkg::fallback_t fallback_q;

	// Stage one: the accepted transfer.
	logic                         valid_s1;
	logic                         cand_valid_s1;
	logic signed [SLOT_BITS:0]    cand_slot_s1;
	logic signed [FRAME_BITS-1:0] cand_frame_s1;
	logic                         last_s1;
	logic signed [FRAME_BITS-1:0] target_s1;
	logic signed [FRAME_BITS-1:0] minimum_s1;
	logic signed [SLOT_BITS:0]    pref_s1;
	logic signed [SLOT_BITS:0]    ret_slot_s1;
	logic signed [FRAME_BITS-1:0] ret_frame_s1;

	// Run state: the latched request and the trackers.
	logic                         run_open_q;
	logic signed [FRAME_BITS-1:0] held_target_q;
	logic signed [FRAME_BITS-1:0] held_min_q;
	logic signed [SLOT_BITS:0]    held_pref_q;
	bfs_pkg::pick_found_t         found_q;
	logic signed [SLOT_BITS:0]    pref_slot_q;
	logic signed [FRAME_BITS-1:0] pref_frame_q;
	logic signed [SLOT_BITS:0]    exact_slot_q;
	logic signed [SLOT_BITS:0]    before_slot_q;
	logic signed [FRAME_BITS-1:0] before_frame_q;
	logic signed [SLOT_BITS:0]    near_slot_q;
	logic signed [FRAME_BITS-1:0] near_frame_q;
	logic [GAP_BITS-1:0]          near_gap_q;

	// Result register.
	logic                         out_valid_q;
	logic signed [SLOT_BITS:0]    res_slot_q;
	logic signed [FRAME_BITS-1:0] res_frame_q;
	bfs_pkg::reason_t             res_reason_q;

	// Stage-one logic.
	logic                         in_fire;
	logic                         advance;
	logic signed [FRAME_BITS-1:0] tgt;
	logic signed [FRAME_BITS-1:0] mnm;
	logic signed [SLOT_BITS:0]    prf;
	bfs_pkg::pick_found_t         base_found;
	bfs_pkg::pick_found_t         nxt_found;
	logic                         eligible;
	logic                         take_pref;
	logic                         take_exact;
	logic                         take_before;
	logic                         take_near;
	logic signed [GAP_BITS-1:0]   diff;
	logic [GAP_BITS-1:0]          gap;
	logic signed [SLOT_BITS:0]    nxt_pref_slot;
	logic signed [FRAME_BITS-1:0] nxt_pref_frame;
	logic signed [SLOT_BITS:0]    nxt_exact_slot;
	logic signed [SLOT_BITS:0]    nxt_before_slot;
	logic signed [FRAME_BITS-1:0] nxt_before_frame;
	logic signed [SLOT_BITS:0]    nxt_near_slot;
	logic signed [FRAME_BITS-1:0] nxt_near_frame;
	logic signed [SLOT_BITS:0]    sel_slot;
	logic signed [FRAME_BITS-1:0] sel_frame;
	bfs_pkg::reason_t             sel_reason;

	// A transfer without a result always leaves stage one; a last transfer
	// leaves only when the result register is free or being emptied.
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	always_comb begin
		// The first transfer of a run supplies the request itself and sees
		// no earlier picks.
		tgt        = run_open_q ? held_target_q : target_s1;
		mnm        = run_open_q ? held_min_q : minimum_s1;
		prf        = run_open_q ? held_pref_q : pref_s1;
		base_found = run_open_q ? found_q : '0;

		eligible = cand_valid_s1 && !cand_slot_s1[SLOT_BITS] &&
			!cand_frame_s1[FRAME_BITS-1] && (cand_frame_s1 > mnm);

		diff = {cand_frame_s1[FRAME_BITS-1], cand_frame_s1} - {tgt[FRAME_BITS-1], tgt};
		gap  = diff[GAP_BITS-1] ? GAP_BITS'(-diff) : GAP_BITS'(diff);

		take_pref   = eligible && (cand_slot_s1 == prf);
		take_exact  = eligible && (cand_frame_s1 == tgt) && !base_found.exact;
		take_before = eligible && (cand_frame_s1 <= tgt) &&
			(!base_found.at_or_before || cand_frame_s1 > before_frame_q);
		take_near   = eligible && (!base_found.nearest || gap < near_gap_q ||
			(gap == near_gap_q && cand_frame_s1 > near_frame_q));

		nxt_found.preferred    = base_found.preferred || take_pref;
		nxt_found.exact        = base_found.exact || take_exact;
		nxt_found.at_or_before = base_found.at_or_before || take_before;
		nxt_found.nearest      = base_found.nearest || take_near;

		nxt_pref_slot    = take_pref   ? cand_slot_s1  : pref_slot_q;
		nxt_pref_frame   = take_pref   ? cand_frame_s1 : pref_frame_q;
		nxt_exact_slot   = take_exact  ? cand_slot_s1  : exact_slot_q;
		nxt_before_slot  = take_before ? cand_slot_s1  : before_slot_q;
		nxt_before_frame = take_before ? cand_frame_s1 : before_frame_q;
		nxt_near_slot    = take_near   ? cand_slot_s1  : near_slot_q;
		nxt_near_frame   = take_near   ? cand_frame_s1 : near_frame_q;
	end

	bfs_select #(
		.FRAME_BITS (FRAME_BITS),
		.SLOT_BITS  (SLOT_BITS)
	) u_select (
		.found        (nxt_found),
		.mode         (fallback_q),
		.target       (tgt),
		.pref_slot    (nxt_pref_slot),
		.pref_frame   (nxt_pref_frame),
		.exact_slot   (nxt_exact_slot),
		.before_slot  (nxt_before_slot),
		.before_frame (nxt_before_frame),
		.near_slot    (nxt_near_slot),
		.near_frame   (nxt_near_frame),
		.kept_slot    (ret_slot_s1),
		.kept_frame   (ret_frame_s1),
		.sel_slot     (sel_slot),
		.sel_frame    (sel_frame),
		.sel_reason   (sel_reason)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q  <= bfs_pkg::FB_EXACT_ONLY;
			valid_s1    <= 1'b0;
			run_open_q  <= 1'b0;
			found_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				fallback_q <= bfs_pkg::fallback_t'(cfg_wr_data);
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				run_open_q <= !last_s1;
				found_q    <= nxt_found;
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cand_valid_s1 <= candidate_valid;
			cand_slot_s1  <= candidate_slot;
			cand_frame_s1 <= candidate_frame;
			last_s1       <= last_candidate;
			target_s1     <= wanted_frame;
			minimum_s1    <= minimum_frame;
			pref_s1       <= favoured_slot;
			ret_slot_s1   <= kept_slot;
			ret_frame_s1  <= kept_frame;
		end
		if (advance) begin
			held_target_q  <= tgt;
			held_min_q     <= mnm;
			held_pref_q    <= prf;
			pref_slot_q    <= nxt_pref_slot;
			pref_frame_q   <= nxt_pref_frame;
			exact_slot_q   <= nxt_exact_slot;
			before_slot_q  <= nxt_before_slot;
			before_frame_q <= nxt_before_frame;
			near_slot_q    <= nxt_near_slot;
			near_frame_q   <= nxt_near_frame;
			if (take_near) begin
				near_gap_q <= gap;
			end
		end
		if (advance && last_s1) begin
			res_slot_q   <= sel_slot;
			res_frame_q  <= sel_frame;
			res_reason_q <= sel_reason;
		end
	end

	assign out_valid        = out_valid_q;
	assign chosen_slot      = res_slot_q;
	assign chosen_frame     = res_frame_q;
	assign selection_reason = res_reason_q;

endmodule

`default_nettype wire

>>> src/bfs_select.sv
// ---------------------------------------------------------------------------
// bfs_select
// Final choice between the tracked picks, the fallback and the retained frame.
// ---------------------------------------------------------------------------
`default_nettype none

module bfs_select #(
	parameter int unsigned FRAME_BITS = bfs_pkg::FRAME_BITS_DEF,
	parameter int unsigned SLOT_BITS  = bfs_pkg::SLOT_BITS_DEF
) (
	input  wire bfs_pkg::pick_found_t    found,
	input  wire bfs_pkg::fallback_t      mode,
	input  wire logic signed [FRAME_BITS-1:0] target,
	input  wire logic signed [SLOT_BITS:0]    pref_slot,
	input  wire logic signed [FRAME_BITS-1:0] pref_frame,
	input  wire logic signed [SLOT_BITS:0]    exact_slot,
	input  wire logic signed [SLOT_BITS:0]    before_slot,
	input  wire logic signed [FRAME_BITS-1:0] before_frame,
	input  wire logic signed [SLOT_BITS:0]    near_slot,
	input  wire logic signed [FRAME_BITS-1:0] near_frame,
	input  wire logic signed [SLOT_BITS:0]    kept_slot,
	input  wire logic signed [FRAME_BITS-1:0] kept_frame,
	output logic signed [SLOT_BITS:0]         sel_slot,
	output logic signed [FRAME_BITS-1:0]      sel_frame,
	output bfs_pkg::reason_t                  sel_reason
);

	logic target_neg;
	logic use_before;
	logic use_nearest;

	always_comb begin
		target_neg  = target[FRAME_BITS-1];
		use_before  = (mode == bfs_pkg::FB_AT_OR_BEFORE) ||
			(mode == bfs_pkg::FB_BEFORE_NEAREST);
		use_nearest = (mode == bfs_pkg::FB_BEFORE_NEAREST) ||
			(mode == bfs_pkg::FB_NEAREST);

		if (found.preferred && (target_neg || pref_frame == target)) begin
			sel_slot   = pref_slot;
			sel_frame  = pref_frame;
			sel_reason = target_neg ? bfs_pkg::REASON_PREFERRED : bfs_pkg::REASON_EXACT;
		end else if (found.exact) begin
			// An exact match always carries the target as its frame.
			sel_slot   = exact_slot;
			sel_frame  = target;
			sel_reason = bfs_pkg::REASON_EXACT;
		end else if (use_before && found.at_or_before) begin
			sel_slot   = before_slot;
			sel_frame  = before_frame;
			sel_reason = bfs_pkg::REASON_BEFORE;
		end else if (use_nearest && found.nearest) begin
			sel_slot   = near_slot;
			sel_frame  = near_frame;
			sel_reason = bfs_pkg::REASON_NEAREST;
		end else if (!kept_frame[FRAME_BITS-1]) begin
			sel_slot   = kept_slot;
			sel_frame  = kept_frame;
			sel_reason = bfs_pkg::REASON_RETAINED;
		end else begin
			sel_slot   = '1;
			sel_frame  = '1;
			sel_reason = bfs_pkg::REASON_NONE;
		end
	end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for buffered_frame_selector: a table of directed runs
// followed by random runs, each selection checked against the predictor or its row.
// ---------------------------------------------------------------------------

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned FRAME_BITS = bfs_pkg::FRAME_BITS_DEF;
	localparam int unsigned SLOT_BITS  = bfs_pkg::SLOT_BITS_DEF;

	localparam int F_MAX = 32'h7fff_ffff;
	localparam int F_MIN = 32'h8000_0000;

	// Cycles allowed for a transfer to pass stage one and the result register.
	localparam int DRAIN_CYCLES    = 4;
	// Length of the deliberate receiver hold-off that fills the pipeline.
	localparam int PRESSURE_CYCLES = 200;
	// Cycles without any transfer before the run is declared hung.
	localparam int QUIET_LIMIT     = 4000;
	localparam int PHASES          = 8;
	localparam int PHASE_ITEMS     = 180;
	localparam int REPORT_LIMIT    = 10;

	// One input transfer, field for field as the ports carry it.
	typedef struct packed {
		logic                         valid;
		logic signed [SLOT_BITS:0]    slot;
		logic signed [FRAME_BITS-1:0] frame;
		logic                         last;
		logic signed [FRAME_BITS-1:0] target;
		logic signed [FRAME_BITS-1:0] minimum;
		logic signed [SLOT_BITS:0]    pref;
		logic signed [SLOT_BITS:0]    kept_slot;
		logic signed [FRAME_BITS-1:0] kept_frame;
	} cand_item_t;

	// One selection as it leaves the block.
	typedef struct packed {
		logic signed [SLOT_BITS:0]    slot;
		logic signed [FRAME_BITS-1:0] frame;
		bfs_pkg::reason_t             reason;
	} selection_t;

	// A tracker of the predictor: a candidate and whether it is held at all.
	typedef struct packed {
		logic                         found;
		logic signed [SLOT_BITS:0]    slot;
		logic signed [FRAME_BITS-1:0] frame;
	} frame_pick_t;

	// A row of the directed table. Where typed is set, the selection is the
	// one written in the row; otherwise the predictor supplies it.
	typedef struct packed {
		bfs_pkg::fallback_t mode;
		cand_item_t         item;
		logic               typed;
		selection_t         want;
	} directed_row_t;

	localparam int NUM_DIRECTED = 24;

	// Fields of item: valid, slot, frame, last, target, minimum, preferred slot,
	// retained slot, retained frame. Request fields after the first transfer
	// of a run are junk on purpose, since the block must ignore them.
	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// Nothing at all after reset, still in exact-only mode.
		'{bfs_pkg::FB_EXACT_ONLY, '{0, -1, 0, 1, 0, 0, -1, -1, -1}, 1,
			'{-1, -1, bfs_pkg::REASON_NONE}},
		// Retained frame with a negative slot is passed through untouched.
		'{bfs_pkg::FB_EXACT_ONLY, '{0, 3, 7, 1, 0, 0, -1, -1, 5}, 1,
			'{-1, 5, bfs_pkg::REASON_RETAINED}},
		// Top slot and top frame, exact match over the lowest minimum.
		'{bfs_pkg::FB_EXACT_ONLY, '{1, 255, F_MAX, 1, F_MAX, F_MIN, -1, 0, 0}, 1,
			'{255, F_MAX, bfs_pkg::REASON_EXACT}},
		// Negative target takes the preferred slot, here slot and frame zero.
		'{bfs_pkg::FB_EXACT_ONLY, '{1, 0, 0, 1, -1, F_MIN, 0, -1, -1}, 1,
			'{0, 0, bfs_pkg::REASON_PREFERRED}},
		// Frame equal to the minimum is not eligible; fall to the retained one.
		'{bfs_pkg::FB_EXACT_ONLY, '{1, 4, 100, 1, 100, 100, -1, 255, F_MAX}, 1,
			'{255, F_MAX, bfs_pkg::REASON_RETAINED}},
		// Negative candidate slot, and a retained frame that is negative.
		'{bfs_pkg::FB_EXACT_ONLY, '{1, -1, 50, 1, 50, 0, -1, 7, F_MIN}, 1,
			'{-1, -1, bfs_pkg::REASON_NONE}},
		// Negative candidate frame in the preferred slot.
		'{bfs_pkg::FB_EXACT_ONLY, '{1, 6, F_MIN, 1, F_MIN, F_MIN, 6, 7, -1}, 1,
			'{-1, -1, bfs_pkg::REASON_NONE}},
		// At or before: ties keep the first of the largest frames.
		'{bfs_pkg::FB_AT_OR_BEFORE, '{1, 3, 90, 0, 100, 10, -1, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_AT_OR_BEFORE, '{1, 4, 95, 0, 0, 0, 0, 0, 0}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_AT_OR_BEFORE, '{1, 5, 95, 1, 0, 0, 0, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		// Nearest: equal distance on both sides goes to the larger frame.
		'{bfs_pkg::FB_NEAREST, '{1, 1, 98, 0, 100, 0, -1, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_NEAREST, '{1, 2, 102, 0, 0, 0, 0, 0, 0}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_NEAREST, '{1, 3, F_MAX, 1, 0, 0, 0, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		// Latest then nearest, with nothing at or before the target.
		'{bfs_pkg::FB_BEFORE_NEAREST, '{1, 1, 20, 0, 10, 0, -1, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_BEFORE_NEAREST, '{1, 2, 15, 1, 0, 0, 0, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		// Widest possible distance between target and candidate.
		'{bfs_pkg::FB_BEFORE_NEAREST, '{1, 9, F_MAX, 1, F_MIN, F_MIN, -1, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		// Preferred slot seen twice; the later match misses the target.
		'{bfs_pkg::FB_BEFORE_NEAREST, '{1, 7, 50, 0, 50, 0, 7, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_BEFORE_NEAREST, '{1, 7, 40, 0, 0, 0, 0, 0, 0}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_BEFORE_NEAREST, '{1, 8, 50, 1, 0, 0, 0, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		// An empty transfer opens the run and its request is the one latched.
		'{bfs_pkg::FB_EXACT_ONLY, '{0, 3, 1000, 0, -5, 0, 3, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_EXACT_ONLY, '{1, 3, 1000, 1, 1000, 0, 9, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		// A run of empty transfers only.
		'{bfs_pkg::FB_EXACT_ONLY, '{0, 0, 0, 0, 5, 0, -1, -1, -1}, 0,
			'{0, 0, bfs_pkg::REASON_NONE}},
		'{bfs_pkg::FB_EXACT_ONLY, '{0, 0, 0, 1, 0, 0, 0, 12, 0}, 1,
			'{12, 0, bfs_pkg::REASON_RETAINED}},
		// Highest minimum: no frame can exceed it.
		'{bfs_pkg::FB_EXACT_ONLY, '{1, 1, F_MAX, 1, F_MAX, F_MAX, 1, -1, -1}, 1,
			'{-1, -1, bfs_pkg::REASON_NONE}}
	};

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_wr_en;
	logic [1:0]                   cfg_wr_data;
	logic                         in_valid;
	logic                         in_stall;
	logic                         candidate_valid;
	logic signed [SLOT_BITS:0]    candidate_slot;
	logic signed [FRAME_BITS-1:0] candidate_frame;
	logic                         last_candidate;
	logic signed [FRAME_BITS-1:0] wanted_frame;
	logic signed [FRAME_BITS-1:0] minimum_frame;
	logic signed [SLOT_BITS:0]    favoured_slot;
	logic signed [SLOT_BITS:0]    kept_slot;
	logic signed [FRAME_BITS-1:0] kept_frame;
	logic                         out_valid;
	logic                         out_stall;
	logic signed [SLOT_BITS:0]    chosen_slot;
	logic signed [FRAME_BITS-1:0] chosen_frame;
	logic [2:0]                   selection_reason;

	buffered_frame_selector #(
		.FRAME_BITS(FRAME_BITS),
		.SLOT_BITS (SLOT_BITS)
	) u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.candidate_valid (candidate_valid),
		.candidate_slot  (candidate_slot),
		.candidate_frame (candidate_frame),
		.last_candidate  (last_candidate),
		.wanted_frame    (wanted_frame),
		.minimum_frame   (minimum_frame),
		.favoured_slot   (favoured_slot),
		.kept_slot       (kept_slot),
		.kept_frame      (kept_frame),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.chosen_slot     (chosen_slot),
		.chosen_frame    (chosen_frame),
		.selection_reason(selection_reason)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predictor state: the bench's own copy of the open run, the latched
	// request, the four trackers and the fallback register.
	logic                         run_open;
	logic signed [FRAME_BITS-1:0] held_target;
	logic signed [FRAME_BITS-1:0] held_minimum;
	logic signed [SLOT_BITS:0]    held_pref;
	frame_pick_t                  pick_pref;
	frame_pick_t                  pick_exact;
	frame_pick_t                  pick_before;
	frame_pick_t                  pick_near;
	longint                       near_gap;
	bfs_pkg::fallback_t           fallback_now;

	// Selections predicted but not yet seen on the output, oldest first.
	selection_t expected_selections [$];

	int  send_idle_pct     = 0;
	int  stall_pct         = 0;
	bit  pressure_request  = 1'b0;
	int  items_sent        = 0;
	int  mismatches        = 0;

	function automatic void clear_trackers();
		pick_pref   = '0;
		pick_exact  = '0;
		pick_before = '0;
		pick_near   = '0;
		near_gap    = (64'sd1 <<< 33) - 1;
	endfunction

	// Advances the predictor by one accepted transfer. Returns 1 when the
	// transfer closes a run, with the selection the block must then produce.
	function automatic bit select_frame(input cand_item_t it, output selection_t sel);
		longint aim;
		longint min_f;
		longint fav;
		longint slot;
		longint frame;
		longint gap;
		if (!run_open) begin
			held_target  = it.target;
			held_minimum = it.minimum;
			held_pref    = it.pref;
			clear_trackers();
			run_open = 1'b1;
		end
		aim   = held_target;
		min_f = held_minimum;
		fav   = held_pref;
		slot  = it.slot;
		frame = it.frame;
		sel   = '{-1, -1, bfs_pkg::REASON_NONE};

		if (it.valid && slot >= 0 && frame >= 0 && frame > min_f) begin
			// The preferred tracker keeps the latest match, the exact one the first.
			if (slot == fav)
				pick_pref = '{1'b1, it.slot, it.frame};
			if (frame == aim && !pick_exact.found)
				pick_exact = '{1'b1, it.slot, it.frame};
			if (frame <= aim && (!pick_before.found || frame > pick_before.frame))
				pick_before = '{1'b1, it.slot, it.frame};
			gap = (frame >= aim) ? frame - aim : aim - frame;
			if (!pick_near.found || gap < near_gap ||
			    (gap == near_gap && frame > pick_near.frame)) begin
				pick_near = '{1'b1, it.slot, it.frame};
				near_gap  = gap;
			end
		end

		if (!it.last)
			return 1'b0;
		run_open = 1'b0;

		if (pick_pref.found && (aim < 0 || pick_pref.frame == aim))
			sel = '{pick_pref.slot, pick_pref.frame,
				(aim < 0) ? bfs_pkg::REASON_PREFERRED : bfs_pkg::REASON_EXACT};
		else if (pick_exact.found)
			sel = '{pick_exact.slot, pick_exact.frame, bfs_pkg::REASON_EXACT};
		else if ((fallback_now == bfs_pkg::FB_AT_OR_BEFORE ||
		          fallback_now == bfs_pkg::FB_BEFORE_NEAREST) && pick_before.found)
			sel = '{pick_before.slot, pick_before.frame, bfs_pkg::REASON_BEFORE};
		else if ((fallback_now == bfs_pkg::FB_BEFORE_NEAREST ||
		          fallback_now == bfs_pkg::FB_NEAREST) && pick_near.found)
			sel = '{pick_near.slot, pick_near.frame, bfs_pkg::REASON_NEAREST};
		else if (it.kept_frame >= 0)
			sel = '{it.kept_slot, it.kept_frame, bfs_pkg::REASON_RETAINED};
		return 1'b1;
	endfunction

	// Offers one transfer after a random number of idle cycles, holds it
	// steady while the block stalls, and records the predicted selection on
	// the edge where the transfer takes place. Inputs are only changed at a
	// rising edge; in_stall is looked at on the falling edge, when it has
	// settled for the coming rising edge.
	task automatic send_item(input cand_item_t it, input bit typed, input selection_t want);
		selection_t sel;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		candidate_valid <= it.valid;
		candidate_slot  <= it.slot;
		candidate_frame <= it.frame;
		last_candidate  <= it.last;
		wanted_frame    <= it.target;
		minimum_frame   <= it.minimum;
		favoured_slot   <= it.pref;
		kept_slot       <= it.kept_slot;
		kept_frame      <= it.kept_frame;
		@(negedge clk);
		while (in_stall !== 1'b0)
			@(negedge clk);
		@(posedge clk);
		items_sent++;
		if (select_frame(it, sel))
			expected_selections.push_back(typed ? want : sel);
	endtask

	// The fallback register may only change with the block empty, so wait
	// for every outstanding selection and then let the pipeline drain.
	task automatic set_fallback(input bfs_pkg::fallback_t mode);
		in_valid <= 1'b0;
		while (expected_selections.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= mode;
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		fallback_now = mode;
	endtask

	// One well-formed run with random content. Frames are mostly placed
	// around the latched target so that every tracker gets work, with the
	// odd wild value to toggle every bit of the wide fields.
	task automatic send_random_run();
		cand_item_t                   it;
		int unsigned                  len;
		int unsigned                  k;
		logic signed [FRAME_BITS-1:0] aim;
		logic signed [FRAME_BITS-1:0] min_f;
		logic signed [SLOT_BITS:0]    fav;
		len = ($urandom_range(19) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
		case ($urandom_range(9)) inside
			0: aim = $urandom;
			[1:2]: aim = 0 - $urandom_range(1, 1000);
			default: aim = $urandom_range(0, 300);
		endcase
		case ($urandom_range(7))
			0: min_f = $urandom;
			1: min_f = F_MIN;
			default: min_f = $urandom_range(0, 40) - 20;
		endcase
		case ($urandom_range(9)) inside
			[0:1]: fav = -1;
			2: fav = $urandom_range(0, 255);
			default: fav = $urandom_range(0, 15);
		endcase
		for (k = 0; k < len; k++) begin
			it.valid = ($urandom_range(9) != 0);
			case ($urandom_range(19)) inside
				0: it.slot = -1;
				[1:2]: it.slot = $urandom_range(0, 255);
				[3:7]: it.slot = fav;
				default: it.slot = $urandom_range(0, 15);
			endcase
			case ($urandom_range(19)) inside
				0: it.frame = $urandom;
				1: it.frame = 0 - $urandom_range(1, 1000);
				2: it.frame = min_f;
				[3:4]: it.frame = aim;
				default: begin
					if (aim < 0)
						it.frame = $urandom_range(0, 300);
					else
						it.frame = aim + $urandom_range(0, 60) - 30;
				end
			endcase
			it.last = (k == len - 1);
			// Only the first transfer's request counts; the rest is noise.
			it.target  = (k == 0) ? aim : $urandom;
			it.minimum = (k == 0) ? min_f : $urandom;
			it.pref    = (k == 0) ? fav : $urandom_range(0, 256) - 1;
			it.kept_slot = ($urandom_range(9) == 0) ? -1 : $urandom_range(0, 255);
			case ($urandom_range(9)) inside
				[0:3]: it.kept_frame = $urandom;
				4: it.kept_frame = -1;
				default: it.kept_frame = $urandom_range(0, 300);
			endcase
			send_item(it, 1'b0, '0);
		end
	endtask

	// Main stimulus: reset, the directed table, then phases of random runs
	// under different fallback modes and idling patterns.
	initial begin : stimulus
		int phase_start;
		bit pressure_done;
		arst_n          = 1'b0;
		cfg_wr_en       = 1'b0;
		cfg_wr_data     = bfs_pkg::FB_EXACT_ONLY;
		in_valid        = 1'b0;
		candidate_valid = 1'b0;
		candidate_slot  = '0;
		candidate_frame = '0;
		last_candidate  = 1'b0;
		wanted_frame    = '0;
		minimum_frame   = '0;
		favoured_slot   = '0;
		kept_slot       = '0;
		kept_frame      = '0;
		pressure_done   = 1'b0;
		run_open        = 1'b0;
		held_target     = '0;
		held_minimum    = '0;
		held_pref       = '0;
		fallback_now    = bfs_pkg::FB_EXACT_ONLY;
		clear_trackers();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The mode is only switched between runs, and the first rows rely on
		// the reset value of the register.
		for (int r = 0; r < NUM_DIRECTED; r++) begin
			if (!run_open && directed_rows[r].mode != fallback_now)
				set_fallback(directed_rows[r].mode);
			send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			set_fallback(bfs_pkg::fallback_t'(phase % 4));
			case ((phase / 2) % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 60;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 60;
				end
				default: begin
					send_idle_pct = 33;
					stall_pct     = 33;
				end
			endcase
			phase_start = items_sent;
			while (items_sent - phase_start < PHASE_ITEMS) begin
				// In the first phase the sender never idles, so a long hold-off
				// on the output backs the block up until it stalls its input.
				if (phase == 0 && !pressure_done && items_sent - phase_start >= 60) begin
					pressure_request = 1'b1;
					pressure_done    = 1'b1;
				end
				send_random_run();
			end
		end

		in_valid <= 1'b0;
		while (expected_selections.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_selections.size() == 0)
			$display("PASS buffered_frame_selector");
		else
			$display("FAIL buffered_frame_selector");
		$finish;
	end

	// Receiver side: random stalls at the rate of the current phase, and one
	// long hold-off, counted here, when the stimulus asks for it.
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_request) begin
				pressure_request = 1'b0;
				out_stall <= 1'b1;
				repeat (PRESSURE_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Checks each output transfer against the oldest predicted selection.
	// Sampled on the falling edge, where the values that the next rising edge
	// transfers are already stable.
	initial begin : result_check
		selection_t want;
		forever begin
			@(negedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (expected_selections.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("unexpected selection: slot %0d frame %0d reason %0d",
							chosen_slot, chosen_frame, selection_reason);
					mismatches++;
				end else begin
					want = expected_selections.pop_front();
					if (chosen_slot !== want.slot || chosen_frame !== want.frame ||
					    selection_reason !== want.reason) begin
						if (mismatches < REPORT_LIMIT)
							$display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
								want.slot, want.frame, want.reason,
								chosen_slot, chosen_frame, selection_reason);
						mismatches++;
					end
				end
			end
		end
	end

	// Ends a hung run: too many cycles in a row with no transfer on either side.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(negedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
			    (out_valid === 1'b1 && out_stall === 1'b0))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAIL buffered_frame_selector");
		$finish;
	end

endmodule

>>> sim.f
src/bfs_pkg.sv
src/bfs_select.sv
src/buffered_frame_selector.sv
tb/tb_top.sv
